>>> rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, command codes and the command and response beat types.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH   = 1024;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FUNC_W  = 3;
  localparam int WORD_W  = 32;
  localparam int ENTRY_W = 11;

  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_STATUS     = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic                     failed;
    logic [ENTRY_W-1:0]       entry_count;
    logic                     is_empty;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
  } rsp_t;

endpackage

>>> rtl/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque slot memory
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int Depth = 1024,
  parameter int Width = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                        rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Ring-buffer deque of signed 32-bit words with push/pop at either end.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload   Beat taken when
//   command   start / busy          cmd       start high and busy low
//   response  done (strobe only)    rsp       done high, one cycle only
//
// Every command beat yields exactly one response beat. Pushes, status queries
// and failed pops answer in the cycle after the command is taken and leave
// busy low, so one such command can be taken every cycle while no pop holds
// busy. A successful pop waits for the slot behind the removed end to come back
// from the registered RAM read port as the new end word; busy is high for a
// single cycle meanwhile. Reset is synchronous and empties the queue at once;
// no clearing pass is run since only slots that were pushed are ever used.
// The receiver cannot stall: each response is shown for one cycle only.
//
// The words at both ends are cached in registers, so a pop returns its word
// straight from the cache and a push updates the cache directly; the RAM only
// supplies the neighbor of an end that has just been popped.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  deq_pkg::cmd_t cmd,
  output logic          done,
  output deq_pkg::rsp_t rsp
);

  import deq_pkg::*;

  // Ring pointers. The back pointer always sits one slot behind the front
  // pointer plus the count, so an empty queue has back = front - 1.
  logic [IDX_W-1:0]  front_idx, front_idx_next;
  logic [IDX_W-1:0]  back_idx, back_idx_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [WORD_W-1:0] front_word, front_word_next;
  logic [WORD_W-1:0] back_word, back_word_next;

  // Pop in flight: waiting for the RAM to return the new end word.
  logic              pend;
  logic              pend_front;
  logic [WORD_W-1:0] popped_hold;

  logic              accept;
  logic              full;
  logic              empty;
  logic              fail;
  logic              start_pop;
  logic [WORD_W-1:0] popped;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [CNT_W+ENTRY_W-1:0] count_wide;
  logic [CNT_W+ENTRY_W-1:0] count_next_wide;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    return r;
  endfunction

  assign busy   = pend;
  assign accept = start && !pend;
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  // Entry count field is the held count truncated or zero-extended to 11 bits.
  assign count_wide      = {{ENTRY_W{1'b0}}, count};
  assign count_next_wide = {{ENTRY_W{1'b0}}, count_next};

  // Command decode and next-state for the accepting cycle.
  always_comb begin
    front_idx_next  = front_idx;
    back_idx_next   = back_idx;
    count_next      = count;
    front_word_next = front_word;
    back_word_next  = back_word;
    fail            = 1'b0;
    start_pop       = 1'b0;
    popped          = '0;
    ram_we          = 1'b0;
    ram_waddr       = front_idx;
    ram_re          = 1'b0;
    ram_raddr       = front_idx;

    if (accept) begin
      unique case (cmd.func)
        FUNC_PUSH_FRONT: begin
          if (full) begin
            fail = 1'b1;
          end else begin
            front_idx_next  = idx_dec(front_idx);
            count_next      = count + CNT_W'(1);
            front_word_next = cmd.push_value;
            if (empty) begin
              back_word_next = cmd.push_value;
            end
            ram_we    = 1'b1;
            ram_waddr = front_idx_next;
          end
        end
        FUNC_PUSH_BACK: begin
          if (full) begin
            fail = 1'b1;
          end else begin
            back_idx_next  = idx_inc(back_idx);
            count_next     = count + CNT_W'(1);
            back_word_next = cmd.push_value;
            if (empty) begin
              front_word_next = cmd.push_value;
            end
            ram_we    = 1'b1;
            ram_waddr = back_idx_next;
          end
        end
        FUNC_POP_FRONT: begin
          if (empty) begin
            fail = 1'b1;
          end else begin
            popped         = front_word;
            front_idx_next = idx_inc(front_idx);
            count_next     = count - CNT_W'(1);
            start_pop      = 1'b1;
            ram_re         = 1'b1;
            ram_raddr      = front_idx_next;
          end
        end
        FUNC_POP_BACK: begin
          if (empty) begin
            fail = 1'b1;
          end else begin
            popped        = back_word;
            back_idx_next = idx_dec(back_idx);
            count_next    = count - CNT_W'(1);
            start_pop     = 1'b1;
            ram_re        = 1'b1;
            ram_raddr     = back_idx_next;
          end
        end
        default: begin
          // Status query and the unused codes leave the state alone.
        end
      endcase
    end
  end

  deq_ram #(
    .Depth (DEPTH),
    .Width (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front_idx  <= '0;
      back_idx   <= IDX_W'(DEPTH - 1);
      count      <= '0;
      front_word <= '0;
      back_word  <= '0;
      pend       <= 1'b0;
      pend_front <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (pend) begin
        // The RAM now holds the word that became the new end. When the pop
        // emptied the queue both cached ends go back to zero.
        pend <= 1'b0;
        done <= 1'b1;
        rsp.popped_value <= popped_hold;
        rsp.failed       <= 1'b0;
        rsp.entry_count  <= count_wide[ENTRY_W-1:0];
        rsp.is_empty     <= empty;
        if (empty) begin
          front_word       <= '0;
          back_word        <= '0;
          rsp.front_value  <= '0;
          rsp.back_value   <= '0;
        end else if (pend_front) begin
          front_word       <= ram_rdata;
          rsp.front_value  <= ram_rdata;
          rsp.back_value   <= back_word;
        end else begin
          back_word        <= ram_rdata;
          rsp.front_value  <= front_word;
          rsp.back_value   <= ram_rdata;
        end
      end else if (accept) begin
        front_idx  <= front_idx_next;
        back_idx   <= back_idx_next;
        count      <= count_next;
        front_word <= front_word_next;
        back_word  <= back_word_next;
        if (start_pop) begin
          pend        <= 1'b1;
          pend_front  <= (cmd.func == FUNC_POP_FRONT);
          popped_hold <= popped;
        end else begin
          done <= 1'b1;
          rsp.popped_value <= '0;
          rsp.failed       <= fail;
          rsp.entry_count  <= count_next_wide[ENTRY_W-1:0];
          rsp.is_empty     <= (count_next == '0);
          rsp.front_value  <= front_word_next;
          rsp.back_value   <= back_word_next;
        end
      end
    end
  end

endmodule

>>> rtl/deq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue port checker
// Watches the top-level ports for response timing and response consistency.
// ----------------------------------------------------------------------------
module deq_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input deq_pkg::rsp_t rsp
);

  import deq_pkg::*;

  // A taken command either answers next cycle or holds the port busy.
  a_accept_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("command beat got neither a response nor a busy cycle");

  // The busy window lasts one cycle and ends with the response.
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("busy window did not close with a response");

  // An empty queue reports zero entries and zero end words.
  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.is_empty) |->
      (rsp.entry_count == '0 && rsp.front_value == '0 && rsp.back_value == '0))
    else $error("empty response carries stale contents");

  // A failed command never returns a popped word.
  a_fail_no_word: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.failed) |-> (rsp.popped_value == '0))
    else $error("failed command returned a word");

  // Coming out of reset nothing is pending.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> (!busy && !done))
    else $error("activity right after reset");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

>>> sim/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Sends command beats at both ends of the deque and checks every response
// against a cycle-free model of the ring buffer that the bench keeps itself.
// ----------------------------------------------------------------------------
//
// A short directed sequence covers the empty queue, extreme words, every
// command code (the spare codes too) and a single-entry queue. Random traffic
// follows in phases. It wanders near empty, fills the queue to the brim with a
// push-heavy mix, rides the full boundary so that pushes are dropped, then
// drains with a pop-heavy mix. The sender idles at random, except for a long
// stretch of back-to-back beats in the middle of the fill phase.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
  import deq_pkg::*;

  // Spare command codes. The block treats them as status queries.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

  localparam int RESET_CYCLES = 11;
  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 8;     // quiet time after the last response
  localparam int IDLE_PCT     = 14;
  localparam int BURST_FIRST  = 500;   // first beat of the burst sent with no idling
  localparam int BURST_LAST   = 800;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic done;
  rsp_t rsp;

  double_ended_queue u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Commands waiting to be sent, and the responses that commands already
  // taken by the block must still produce, oldest first.
  cmd_t pending_cmds[$];
  rsp_t expected_rsps[$];

  int cmd_beats   = 0;
  int fault_count = 0;
  int stall_count = 0;

  // Queue occupancy as the stimulus generator sees it. It only steers the
  // phases of the random traffic and has no part in the checking.
  int gen_count = 0;

  // --------------------------------------------------------------------------
  // Deque model: a ring of DEPTH words with a head slot and an entry count.
  // --------------------------------------------------------------------------
  logic signed [WORD_W-1:0] word_ring [DEPTH];
  int head_slot  = 0;
  int word_total = 0;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      word_ring[i] = '0;
    end
  end

  // Applies one command to the ring and returns the response it should give.
  function automatic rsp_t deque_apply(cmd_t c);
    rsp_t r;
    int   tail_slot;
    r = '0;
    case (c.func)
      FUNC_PUSH_FRONT: begin
        if (word_total >= DEPTH) begin
          r.failed = 1'b1;
        end else begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          word_ring[head_slot] = c.push_value;
          word_total++;
        end
      end
      FUNC_PUSH_BACK: begin
        if (word_total >= DEPTH) begin
          r.failed = 1'b1;
        end else begin
          word_ring[(head_slot + word_total) % DEPTH] = c.push_value;
          word_total++;
        end
      end
      FUNC_POP_FRONT: begin
        if (word_total == 0) begin
          r.failed = 1'b1;
        end else begin
          r.popped_value = word_ring[head_slot];
          head_slot = (head_slot + 1) % DEPTH;
          word_total--;
        end
      end
      FUNC_POP_BACK: begin
        if (word_total == 0) begin
          r.failed = 1'b1;
        end else begin
          r.popped_value = word_ring[(head_slot + word_total - 1) % DEPTH];
          word_total--;
        end
      end
      default: begin
        // Status query and spare codes leave the ring untouched.
      end
    endcase
    r.entry_count = ENTRY_W'(word_total);
    r.is_empty    = (word_total == 0);
    if (word_total != 0) begin
      tail_slot     = (head_slot + word_total - 1) % DEPTH;
      r.front_value = word_ring[head_slot];
      r.back_value  = word_ring[tail_slot];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic queue_cmd(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] v);
    cmd_t c;
    c.func       = f;
    c.push_value = v;
    pending_cmds.insert(pending_cmds.size(), c);
    if ((f == FUNC_PUSH_FRONT || f == FUNC_PUSH_BACK) && gen_count < DEPTH) begin
      gen_count++;
    end else if ((f == FUNC_POP_FRONT || f == FUNC_POP_BACK) && gen_count > 0) begin
      gen_count--;
    end
  endtask

  // Mostly uniform words, with the sign boundaries and zero now and then.
  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // One random command: push_pct percent pushes, pop_pct percent pops, and
  // the rest status queries, the spare codes included.
  task automatic queue_random(int push_pct, int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      queue_cmd($urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, random_word());
    end else if (roll < push_pct + pop_pct) begin
      queue_cmd($urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT, $urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       queue_cmd(FUNC_SPARE_LO, $urandom);
        1:       queue_cmd(FUNC_SPARE_MID, $urandom);
        2:       queue_cmd(FUNC_SPARE_HI, $urandom);
        default: queue_cmd(FUNC_STATUS, $urandom);
      endcase
    end
  endtask

  // The sender idles at random, apart from one long burst of back-to-back
  // beats.
  function automatic logic take_break();
    if (cmd_beats >= BURST_FIRST && cmd_beats < BURST_LAST) begin
      return 1'b0;
    end
    return ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // --------------------------------------------------------------------------
  // Driver. A command beat is taken at an edge where start is high and busy is
  // low; the model is advanced at that same edge. A command that meets busy
  // stays on the port until it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic send_next;
    send_next = 1'b0;
    if (rst) begin
      start <= 1'b0;
      cmd   <= '0;
    end else begin
      if (start && !busy) begin
        expected_rsps.insert(expected_rsps.size(), deque_apply(cmd));
        pending_cmds.delete(0);
        cmd_beats++;
        send_next = (pending_cmds.size() != 0) && !take_break();
      end else if (start) begin
        send_next = 1'b1;
      end else begin
        send_next = (pending_cmds.size() != 0) && !take_break();
      end
      if (send_next) begin
        start <= 1'b1;
        cmd   <= pending_cmds[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Every response beat is matched against the oldest expectation,
  // field by field.
  // --------------------------------------------------------------------------
  task automatic check_field(string field, logic signed [63:0] want,
                             logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $error("response beat with no command waiting for it");
        fault_count++;
      end else begin
        want = expected_rsps[0];
        expected_rsps.delete(0);
        check_field("popped_value", 64'(want.popped_value), 64'(rsp.popped_value));
        check_field("failed", 64'(want.failed), 64'(rsp.failed));
        check_field("entry_count", 64'(want.entry_count), 64'(rsp.entry_count));
        check_field("is_empty", 64'(want.is_empty), 64'(rsp.is_empty));
        check_field("front_value", 64'(want.front_value), 64'(rsp.front_value));
        check_field("back_value", 64'(want.back_value), 64'(rsp.back_value));
      end
    end
  end

  // Watchdog: ends the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("tb_double_ended_queue: FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test.
  // --------------------------------------------------------------------------
  initial begin
    rst = 1'b1;

    // Directed: the empty queue first, then extreme words at both ends.
    queue_cmd(FUNC_STATUS, '0);
    queue_cmd(FUNC_POP_FRONT, '0);
    queue_cmd(FUNC_POP_BACK, '1);
    queue_cmd(FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
    queue_cmd(FUNC_PUSH_BACK, 32'h8000_0000);
    queue_cmd(FUNC_STATUS, '1);
    queue_cmd(FUNC_PUSH_FRONT, '0);
    queue_cmd(FUNC_PUSH_BACK, '1);
    queue_cmd(FUNC_PUSH_FRONT, 32'h5555_5555);
    queue_cmd(FUNC_PUSH_BACK, 32'hAAAA_AAAA);
    // Spare codes must behave as status queries.
    queue_cmd(FUNC_SPARE_LO, 32'h1234_5678);
    queue_cmd(FUNC_SPARE_MID, '1);
    queue_cmd(FUNC_SPARE_HI, '0);
    // Take all six words back out from alternating ends.
    repeat (3) begin
      queue_cmd(FUNC_POP_FRONT, '0);
      queue_cmd(FUNC_POP_BACK, '0);
    end
    queue_cmd(FUNC_POP_FRONT, '0);
    // A single entry is both front and back word.
    queue_cmd(FUNC_PUSH_BACK, 32'd1);
    queue_cmd(FUNC_POP_FRONT, '0);
    queue_cmd(FUNC_PUSH_FRONT, 32'hFFFF_FFFE);
    queue_cmd(FUNC_POP_BACK, '0);

    // Random traffic near empty, where failed pops are common.
    repeat (50) queue_random(45, 45);
    // Fill to the brim. The ring wraps on both ends along the way.
    while (gen_count < DEPTH) queue_random(97, 2);
    // Ride the full boundary so that pushes get dropped.
    repeat (40) queue_random(60, 30);
    // Drain part of the queue, then mix again.
    repeat (120) queue_random(15, 80);
    repeat (40) queue_random(45, 45);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || expected_rsps.size() != 0) begin
      @(posedge clk);
    end
    // A few more cycles so that a stray extra response would still be caught.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("tb_double_ended_queue: PASS");
    end else begin
      $display("tb_double_ended_queue: FAIL");
    end
    $finish;
  end

endmodule
